// ===== sv/aiopga_pkg.sv =====
// Package for the arcade I/O port gate array.
// Holds field widths, item kind codes, register indexes, reset values and shared types.
// No dependencies; every other file imports it.
package aiopga_pkg;

  localparam int KIND_W      = 2;
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 8;
  localparam int PAD_W       = 16;
  localparam int SYS_W       = 8;
  localparam int ELAPSED_W   = 20;
  localparam int GUN_W       = 16;
  localparam int SCHEME_W    = 2;
  localparam int PULSE_W     = 17;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int NPORTS      = 8;
  localparam int PORT_SEL_W  = 3;
  localparam int COINS_W     = 16;
  localparam int TIMER_W     = 18;
  localparam int POS_W       = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_COIN  = 2'd3
  } kind_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_SCHEME    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COIN_PULSE_LENGTH = 1'd1;

  localparam logic [SCHEME_W-1:0] SCHEME_PADS   = 2'd0;
  localparam logic [SCHEME_W-1:0] SCHEME_ROTARY = 2'd1;
  localparam logic [SCHEME_W-1:0] SCHEME_HAMMER = 2'd2;

  localparam logic [ADDR_W-1:0]  DIR_ADDR         = 8'd8;
  localparam logic [PULSE_W-1:0] PULSE_LEN_RESET  = 17'd75000;
  localparam logic [DATA_W-1:0]  LATCH_RESET      = 8'hFF;
  localparam logic [DATA_W-1:0]  DIR_RESET        = 8'hFF;
  localparam logic [COINS_W-1:0] COINS_MAX        = 16'hFFFF;

  typedef logic [NPORTS-1:0][DATA_W-1:0] ports_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ADDR_W-1:0]      addr;
    logic [DATA_W-1:0]      wdata;
    logic [PAD_W-1:0]       pad1_buttons;
    logic [PAD_W-1:0]       pad2_buttons;
    logic [SYS_W-1:0]       system_buttons;
    logic [ELAPSED_W-1:0]   elapsed;
    logic signed [GUN_W-1:0] gun_x;
    logic signed [GUN_W-1:0] gun_y;
    logic                   gun_trigger;
  } item_t;

  typedef struct packed {
    logic [COINS_W-1:0]        coins_waiting;
    logic signed [TIMER_W-1:0] coin_timer;
    logic [POS_W-1:0]          hammer_col;
    logic [POS_W-1:0]          hammer_row;
  } tick_state_t;

endpackage

// ===== sv/aiopga_tick.sv =====
// Input sampler: rebuilds the eight input ports on an update tick.
// Covers pad mapping, hammer gun position, system buttons and the coin pulse timer.
// Depends on aiopga_pkg.
module aiopga_tick (
  input  aiopga_pkg::item_t                          item,
  input  logic [aiopga_pkg::SCHEME_W-1:0]            scheme,
  input  logic [aiopga_pkg::PULSE_W-1:0]             pulse_len,
  input  aiopga_pkg::tick_state_t                    cur,
  output aiopga_pkg::ports_t                         ports,
  output aiopga_pkg::tick_state_t                    nxt
);
  import aiopga_pkg::*;

  // Biased position arithmetic keeps both values non-negative before the shift.
  localparam logic signed [24:0] X_SCALE = 25'sd193;
  localparam logic signed [24:0] X_BIAS  = 25'sd8421376;
  localparam logic signed [23:0] Y_OFS   = 24'sd7;
  localparam logic signed [23:0] Y_SCALE = 24'sd49;
  localparam logic signed [23:0] Y_BIAS  = 24'sd2097280;
  localparam logic [7:0]  X_ZERO = 8'd128;
  localparam logic [7:0]  X_LO   = 8'd125;
  localparam logic [7:0]  X_HI   = 8'd193;
  localparam logic [7:0]  X_CLIP = 8'd190;
  localparam logic [13:0] Y_ZERO = 14'd8192;
  localparam logic [13:0] Y_LO   = 14'd8189;
  localparam logic [13:0] Y_HI   = 14'd8241;
  localparam logic [13:0] Y_CLIP = 14'd8238;
  localparam logic [POS_W-1:0] COL_MAX = 6'd62;
  localparam logic [POS_W-1:0] ROW_MAX = 6'd46;

  function automatic logic [DATA_W-1:0] scramble6(input logic [POS_W-1:0] h);
    return {h[2], h[3], h[0], h[1], 2'b00, h[5], h[4]};
  endfunction

  function automatic logic [DATA_W-1:0] pad_flip(input logic [PAD_W-1:0] t);
    return {t[6], t[7], t[4], t[5], 1'b0, t[9], t[8], t[10]};
  endfunction

  function automatic logic [2:0] rotary_clear(input logic [PAD_W-1:0] t);
    return (t[0] ? 3'd3 : 3'd0) | (t[1] ? 3'd5 : 3'd0) |
           (t[2] ? 3'd6 : 3'd0) | (t[3] ? 3'd7 : 3'd0);
  endfunction

  logic signed [GUN_W-1:0] gx, gy;
  logic signed [24:0]      sx;
  logic signed [23:0]      sy;
  logic [7:0]              xb;
  logic [13:0]             yb;
  logic                    hit;
  logic [POS_W-1:0]        col_hit, row_hit;

  assign gx  = item.gun_x;
  assign gy  = item.gun_y;
  assign sx  = 25'(gx) * X_SCALE + X_BIAS;
  assign sy  = (24'(gy) + Y_OFS) * Y_SCALE + Y_BIAS;
  assign xb  = sx[23:16];
  assign yb  = sy[21:8];
  assign hit = item.gun_trigger && (xb >= X_LO) && (xb <= X_HI) &&
               (yb >= Y_LO) && (yb <= Y_HI);

  always_comb begin
    if (xb < X_ZERO) begin
      col_hit = '0;
    end else if (xb > X_CLIP) begin
      col_hit = COL_MAX;
    end else begin
      col_hit = POS_W'(xb - X_ZERO);
    end
    if (yb < Y_ZERO) begin
      row_hit = '0;
    end else if (yb > Y_CLIP) begin
      row_hit = ROW_MAX;
    end else begin
      row_hit = POS_W'(yb - Y_ZERO);
    end
  end

  logic signed [21:0] diff, neg_lim, pos_lim;

  assign pos_lim = $signed({5'b0, pulse_len});
  assign neg_lim = -pos_lim;

  always_comb begin
    logic [PAD_W-1:0] t;
    ports = '1;
    nxt   = cur;
    t     = '0;
    if (scheme == SCHEME_HAMMER) begin
      if (hit) begin
        nxt.hammer_col = col_hit;
        nxt.hammer_row = row_hit;
        ports[2][4]    = 1'b0;
      end
      ports[0] = scramble6(nxt.hammer_col);
      ports[1] = scramble6(nxt.hammer_row);
    end else begin
      for (int i = 0; i < 2; i++) begin
        t = (i == 0) ? item.pad1_buttons : item.pad2_buttons;
        ports[i] = ports[i] ^ pad_flip(t);
        if (scheme == SCHEME_ROTARY) begin
          ports[i][2:0] = ports[i][2:0] & ~rotary_clear(t);
        end else begin
          ports[5][4*i +: 3] = ports[5][4*i +: 3] ^ {t[0], t[1], t[2]};
        end
        ports[2][4+i] = ports[2][4+i] ^ t[11];
      end
    end

    ports[2][3:2] = ports[2][3:2] ^ item.system_buttons[3:2];
    ports[2][7]   = ports[2][7] ^ item.system_buttons[4];

    // Coin line: count down, rest at the idle floor, then start the next queued coin.
    diff = 22'(cur.coin_timer) - $signed({2'b00, item.elapsed});
    if (diff < neg_lim) begin
      diff = neg_lim;
    end
    if ((cur.coins_waiting != '0) && (diff == neg_lim)) begin
      diff = pos_lim;
      nxt.coins_waiting = cur.coins_waiting - COINS_W'(1);
    end
    nxt.coin_timer = $signed(diff[TIMER_W-1:0]);
    ports[2][0] = ports[2][0] ^ (diff > 22'sd0);
    ports[3] = '0;
  end

endmodule

// ===== sv/aiopga_regs.sv =====
// Register file of the gate array: configuration, output latches, direction register,
// input ports and sampler state, plus the bus read path. Depends on aiopga_pkg, aiopga_tick.
module aiopga_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [aiopga_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aiopga_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  aiopga_pkg::item_t                   item,
  input  logic                                exec,
  output logic [aiopga_pkg::DATA_W-1:0]       read_data
);
  import aiopga_pkg::*;

  logic [SCHEME_W-1:0] scheme_r;
  logic [PULSE_W-1:0]  pulse_len_r;
  ports_t              ports_r;
  ports_t              latches_r;
  logic [DATA_W-1:0]   dir_r;
  tick_state_t         tstate_r;

  ports_t              tick_ports;
  tick_state_t         tick_nxt;
  logic [PORT_SEL_W-1:0] sel;

  aiopga_tick u_tick (
    .item      (item),
    .scheme    (scheme_r),
    .pulse_len (pulse_len_r),
    .cur       (tstate_r),
    .ports     (tick_ports),
    .nxt       (tick_nxt)
  );

  assign sel = item.addr[PORT_SEL_W-1:0];

  // Addresses above the direction register alias onto the input ports.
  always_comb begin
    read_data = '0;
    if (item.kind == KIND_READ) begin
      if (item.addr == DIR_ADDR) begin
        read_data = dir_r;
      end else begin
        read_data = ports_r[sel] & (dir_r[sel] ? LATCH_RESET : latches_r[sel]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r    <= SCHEME_PADS;
      pulse_len_r <= PULSE_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROL_SCHEME:    scheme_r    <= cfg_wdata[SCHEME_W-1:0];
        CFG_COIN_PULSE_LENGTH: pulse_len_r <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r   <= '0;
      latches_r <= {NPORTS{LATCH_RESET}};
      dir_r     <= DIR_RESET;
      tstate_r  <= '0;
    end else if (exec) begin
      unique case (item.kind)
        KIND_WRITE: begin
          if (item.addr[ADDR_W-1:PORT_SEL_W] == '0) begin
            latches_r[sel] <= item.wdata;
          end else if (item.addr == DIR_ADDR) begin
            dir_r <= item.wdata;
          end
        end
        KIND_READ: ;
        KIND_TICK: begin
          ports_r  <= tick_ports;
          tstate_r <= tick_nxt;
        end
        KIND_COIN: begin
          if (tstate_r.coins_waiting != COINS_MAX) begin
            tstate_r.coins_waiting <= tstate_r.coins_waiting + COINS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/arcade_io_port_gate_array_top.sv =====
// Top level of the arcade I/O port gate array: input register, register file, result register.
// Depends on aiopga_pkg and aiopga_regs (which holds aiopga_tick).
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | kind, addr, wdata, pads, system, elapsed, gun
//   out     | output    | out_valid / out_stall| read_data
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// While an item executes from the input register, the register file updates and the result
// register loads at the same edge. One item is accepted per cycle while in_stall is low; all
// state updates finish in the execute cycle. A stall on the output holds the result register
// and, once the input register is full too, raises in_stall. Synchronous active-low reset
// clears the valid flags and register-file state, not the data registers; no clearing pass.
module arcade_io_port_gate_array_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [aiopga_pkg::KIND_W-1:0]       in_kind,
  input  logic [aiopga_pkg::ADDR_W-1:0]       in_addr,
  input  logic [aiopga_pkg::DATA_W-1:0]       in_wdata,
  input  logic [aiopga_pkg::PAD_W-1:0]        in_pad1_buttons,
  input  logic [aiopga_pkg::PAD_W-1:0]        in_pad2_buttons,
  input  logic [aiopga_pkg::SYS_W-1:0]        in_system_buttons,
  input  logic [aiopga_pkg::ELAPSED_W-1:0]    in_elapsed,
  input  logic signed [aiopga_pkg::GUN_W-1:0] in_gun_x,
  input  logic signed [aiopga_pkg::GUN_W-1:0] in_gun_y,
  input  logic                                in_gun_trigger,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [aiopga_pkg::DATA_W-1:0]       out_read_data,
  input  logic                                cfg_we,
  input  logic [aiopga_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aiopga_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import aiopga_pkg::*;

  item_t             item_r;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              item_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] read_data;
  logic              accept;
  logic              exec;
  logic              out_hold;

  assign out_hold = out_valid_r && out_stall;
  assign exec     = item_valid_r && !out_hold;
  assign in_stall = item_valid_r && out_hold;
  assign accept   = in_valid && !in_stall;

  aiopga_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item_r),
    .exec      (exec),
    .read_data (read_data)
  );

  always_comb begin
    item_valid_nxt = accept || (item_valid_r && !exec);
    out_valid_nxt  = exec || out_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind           <= kind_t'(in_kind);
      item_r.addr           <= in_addr;
      item_r.wdata          <= in_wdata;
      item_r.pad1_buttons   <= in_pad1_buttons;
      item_r.pad2_buttons   <= in_pad2_buttons;
      item_r.system_buttons <= in_system_buttons;
      item_r.elapsed        <= in_elapsed;
      item_r.gun_x          <= in_gun_x;
      item_r.gun_y          <= in_gun_y;
      item_r.gun_trigger    <= in_gun_trigger;
    end
    if (exec) begin
      out_data_r <= read_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

// ===== test/arcade_io_port_gate_array_top_tb.sv =====
// Testbench for the arcade I/O port gate array: a table of directed words, random phases over
// every control scheme and a range of pulse lengths, and a coin queue fill and drain, all scored in order.
// Depends on aiopga_pkg and the arcade_io_port_gate_array_top RTL.
module arcade_io_port_gate_array_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aiopga_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_WORDS = 200;
  localparam int COIN_BATCH  = 20;
  localparam int DRAIN_TICKS = 16;
  localparam logic [SCHEME_W-1:0] SCHEME_SPARE = 2'd3;

  typedef struct packed {
    bit                  set_scheme;
    logic [SCHEME_W-1:0] scheme;
    item_t               word;
    bit                  typed;
    logic [DATA_W-1:0]   want;
  } probe_row_t;

  // Rows that change the control scheme drain the block and write the register first.
  localparam probe_row_t PROBES [26] = '{
    '{0, 0, '{KIND_READ,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  8,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 'hFF},
    '{0, 0, '{KIND_WRITE, 0,    'hA5, 0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_WRITE, 8,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_TICK,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_READ,  5,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_TICK,  0,    0,    'hFFFF,  'hFFFF,  'hFF,  'hFFFFF,  0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  2,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_COIN,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_TICK,  0,    0,    'h0F0F,  'hF0F0,  0,     'hFFFFF,  0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  2,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_WRITE, 9,    'h55, 0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  9,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_WRITE, 8,    'hFF, 0,       0,       0,     0,        0,      0,     0}, 1, 0},
    '{1, 1, '{KIND_TICK,  0,    0,    'hFFFF,  'h000F,  0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{1, 2, '{KIND_TICK,  0,    0,    0,       0,       0,     0,        -1188,  -25,   1}, 1, 0},
    '{0, 0, '{KIND_READ,  0,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_TICK,  0,    0,    0,       0,       0,     0,        -32768, 32767, 1}, 1, 0},
    '{0, 0, '{KIND_READ,  2,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{0, 0, '{KIND_TICK,  0,    0,    0,       0,       0,     0,        22241,  251,   1}, 1, 0},
    '{0, 0, '{KIND_READ,  1,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0},
    '{1, 3, '{KIND_TICK,  0,    0,    'h1234,  'h8421,  0,     0,        0,      0,     0}, 1, 0},
    '{0, 0, '{KIND_READ,  5,    0,    0,       0,       0,     0,        0,      0,     0}, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [ADDR_W-1:0] in_addr = '0;
  logic [DATA_W-1:0] in_wdata = '0;
  logic [PAD_W-1:0] in_pad1_buttons = '0;
  logic [PAD_W-1:0] in_pad2_buttons = '0;
  logic [SYS_W-1:0] in_system_buttons = '0;
  logic [ELAPSED_W-1:0] in_elapsed = '0;
  logic signed [GUN_W-1:0] in_gun_x = '0;
  logic signed [GUN_W-1:0] in_gun_y = '0;
  logic in_gun_trigger = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted copy of the block's registers.
  logic [DATA_W-1:0] port_img [NPORTS];
  logic [DATA_W-1:0] latch_img [NPORTS];
  logic [DATA_W-1:0] dir_img;
  int coins_queued;
  int coin_count_down;
  logic [POS_W-1:0] ham_col;
  logic [POS_W-1:0] ham_row;
  logic [SCHEME_W-1:0] scheme_cfg;
  logic [PULSE_W-1:0] pulse_cfg;

  logic [DATA_W-1:0] read_bytes_due [$];
  logic [DATA_W-1:0] want_byte;
  int words_sent = 0;
  int words_checked = 0;
  int bad_words = 0;
  int cycle_count = 0;

  bit idle_on = 1'b1;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int run_left = 0;
  int stall_roll;

  arcade_io_port_gate_array_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_addr          (in_addr),
    .in_wdata         (in_wdata),
    .in_pad1_buttons  (in_pad1_buttons),
    .in_pad2_buttons  (in_pad2_buttons),
    .in_system_buttons(in_system_buttons),
    .in_elapsed       (in_elapsed),
    .in_gun_x         (in_gun_x),
    .in_gun_y         (in_gun_y),
    .in_gun_trigger   (in_gun_trigger),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] scramble_pos(input logic [POS_W-1:0] h);
    return {h[2], h[3], h[0], h[1], 2'b00, h[5:4]};
  endfunction

  // Applies one word to the predicted registers and returns the byte the block should answer.
  task automatic gate_array_step(input item_t w, output logic [DATA_W-1:0] rd);
    logic [DATA_W-1:0] p [NPORTS];
    logic [PAD_W-1:0] t;
    logic [PORT_SEL_W-1:0] o;
    int nx, ny, x, y, c, lim;
    rd = '0;
    case (w.kind)
      KIND_WRITE: begin
        if (w.addr < NPORTS) latch_img[w.addr[PORT_SEL_W-1:0]] = w.wdata;
        else if (w.addr == DIR_ADDR) dir_img = w.wdata;
      end
      KIND_READ: begin
        if (w.addr == DIR_ADDR) begin
          rd = dir_img;
        end else begin
          o = w.addr[PORT_SEL_W-1:0];
          rd = port_img[o];
          if (!dir_img[o]) rd &= latch_img[o];
        end
      end
      KIND_TICK: begin
        for (int k = 0; k < NPORTS; k++) p[k] = 8'hFF;
        if (scheme_cfg == SCHEME_HAMMER) begin
          nx = $signed(w.gun_x);
          ny = $signed(w.gun_y);
          x = (nx * 193 + 32768) >>> 16;
          y = ((ny + 7) * 49 + 128) >>> 8;
          // Outside the window or with the trigger up the last hit position is kept.
          if (w.gun_trigger && x >= -3 && x <= 65 && y >= -3 && y <= 49) begin
            ham_col = (x < 0) ? 6'd0 : (x > 62) ? 6'd62 : x[POS_W-1:0];
            ham_row = (y < 0) ? 6'd0 : (y > 46) ? 6'd46 : y[POS_W-1:0];
            p[2][4] = 1'b0;
          end
          p[0] = scramble_pos(ham_col);
          p[1] = scramble_pos(ham_row);
        end else begin
          for (int i = 0; i < 2; i++) begin
            t = (i == 0) ? w.pad1_buttons : w.pad2_buttons;
            p[i] ^= {t[6], t[7], t[4], t[5], 1'b0, t[9], t[8], t[10]};
            if (scheme_cfg == SCHEME_ROTARY) begin
              if (t[0]) p[i] &= 8'hFC;
              if (t[1]) p[i] &= 8'hFA;
              if (t[2]) p[i] &= 8'hF9;
              if (t[3]) p[i] &= 8'hF8;
            end else begin
              p[5] ^= {5'b0, t[0], t[1], t[2]} << (4 * i);
            end
            p[2][4+i] ^= t[11];
          end
        end
        p[2] ^= w.system_buttons & 8'h0C;
        p[2][7] ^= w.system_buttons[4];
        // The coin timer runs from +L down to -L; a waiting coin restarts it at +L once it reaches -L.
        lim = pulse_cfg;
        c = coin_count_down - int'(w.elapsed);
        if (c < -lim) c = -lim;
        if (coins_queued != 0 && c == -lim) begin
          c = lim;
          coins_queued--;
        end
        coin_count_down = c;
        p[2][0] ^= (c > 0);
        p[3] = 8'h00;
        for (int k = 0; k < NPORTS; k++) port_img[k] = p[k];
      end
      default: begin
        if (coins_queued < COINS_MAX) coins_queued++;
      end
    endcase
  endtask

  function automatic item_t random_word();
    item_t w;
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (r < 35) w.kind = KIND_READ;
    else if (r < 60) w.kind = KIND_WRITE;
    else if (r < 90) w.kind = KIND_TICK;
    else w.kind = KIND_COIN;
    w.addr = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    w.wdata = 8'($urandom);
    w.pad1_buttons = 16'($urandom);
    w.pad2_buttons = 16'($urandom);
    w.system_buttons = 8'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) w.elapsed = 20'($urandom_range(0, pulse_cfg / 2 + 1));
    else if (r < 8) w.elapsed = 20'($urandom_range(0, 3));
    else w.elapsed = 20'($urandom);
    // Most positions land around the hit window so that its edges get exercised.
    if ($urandom_range(0, 9) < 7) begin
      g = $urandom_range(0, 23800);
      w.gun_x = 16'(g - 1300);
      g = $urandom_range(0, 310);
      w.gun_y = 16'(g - 40);
    end else begin
      w.gun_x = 16'($urandom);
      w.gun_y = 16'($urandom);
    end
    w.gun_trigger = ($urandom_range(0, 3) != 0);
    return w;
  endfunction

  task automatic offer_word(input item_t w, input bit typed, input logic [DATA_W-1:0] want);
    int gap;
    int r;
    logic [DATA_W-1:0] predicted;
    gap = 0;
    if (idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_addr <= w.addr;
    in_wdata <= w.wdata;
    in_pad1_buttons <= w.pad1_buttons;
    in_pad2_buttons <= w.pad2_buttons;
    in_system_buttons <= w.system_buttons;
    in_elapsed <= w.elapsed;
    in_gun_x <= w.gun_x;
    in_gun_y <= w.gun_y;
    in_gun_trigger <= w.gun_trigger;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gate_array_step(w, predicted);
    read_bytes_due.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Stops offering and waits until every pending word has come out and the pipe is empty.
  task automatic settle_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (read_bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CONTROL_SCHEME) scheme_cfg = val[SCHEME_W-1:0];
    else pulse_cfg = val[PULSE_W-1:0];
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words pending", cycle_count,
               read_bytes_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (read_bytes_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("Unexpected word %02h with nothing pending", out_read_data);
      end else begin
        want_byte = read_bytes_due.pop_front();
        if (out_read_data !== want_byte) begin
          bad_words++;
          if (bad_words <= 10)
            $display("read_data mismatch on word %0d: expected %02h, got %02h",
                     words_checked, want_byte, out_read_data);
        end
        words_checked++;
      end
    end
  end

  // Receiver: random stall runs, plus one long hold-off when the stimulus asks for it.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_given != hold_asked) begin
      hold_given++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else if (!idle_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 15);
      end else if (stall_roll < 92) begin
        out_stall <= 1'b1;
        run_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        run_left = $urandom_range(10, 40);
      end
    end
  end

  initial begin
    item_t w;
    logic [SCHEME_W-1:0] sch;
    logic [PULSE_W-1:0] len;
    int leftover;

    foreach (port_img[k]) begin
      port_img[k] = '0;
      latch_img[k] = LATCH_RESET;
    end
    dir_img = DIR_RESET;
    coins_queued = 0;
    coin_count_down = 0;
    ham_col = '0;
    ham_row = '0;
    scheme_cfg = SCHEME_PADS;
    pulse_cfg = PULSE_LEN_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (PROBES[n]) begin
      if (PROBES[n].set_scheme) begin
        settle_outputs();
        write_setting(CFG_CONTROL_SCHEME, {15'd0, PROBES[n].scheme});
      end
      offer_word(PROBES[n].word, PROBES[n].typed, PROBES[n].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sch = SCHEME_PADS;   len = PULSE_LEN_RESET; end
        1: begin sch = SCHEME_ROTARY; len = 17'd1; end
        2: begin sch = SCHEME_HAMMER; len = 17'h1FFFF; end
        3: begin sch = SCHEME_SPARE;  len = 17'd0; end
        4: begin sch = SCHEME_HAMMER; len = 17'($urandom_range(1, 5000)); end
        default: begin
          sch = 2'($urandom_range(0, 3));
          len = 17'($urandom_range(1, 131071));
        end
      endcase
      settle_outputs();
      write_setting(CFG_CONTROL_SCHEME, {15'($urandom), sch});
      write_setting(CFG_COIN_PULSE_LENGTH, len);
      idle_on = (ph != 4);
      if (ph == 2) hold_asked++;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 1 && k == PHASE_WORDS / 2) settle_outputs();
        offer_word(random_word(), 1'b0, 8'h00);
      end
    end

    // Queue a batch of coins, then drain it one coin per tick; the coin line
    // must go quiet exactly when the queue runs out.
    settle_outputs();
    write_setting(CFG_CONTROL_SCHEME, {15'd0, SCHEME_PADS});
    write_setting(CFG_COIN_PULSE_LENGTH, 17'd1);
    idle_on = 1'b0;
    w = random_word();
    w.kind = KIND_WRITE;
    w.addr = DIR_ADDR;
    w.wdata = 8'hFF;
    offer_word(w, 1'b0, 8'h00);
    repeat (COIN_BATCH) begin
      w = random_word();
      w.kind = KIND_COIN;
      offer_word(w, 1'b0, 8'h00);
    end
    repeat (DRAIN_TICKS) begin
      w = random_word();
      w.kind = KIND_TICK;
      w.elapsed = '1;
      offer_word(w, 1'b0, 8'h00);
    end
    repeat (8) begin
      w = random_word();
      w.kind = KIND_TICK;
      w.elapsed = '1;
      offer_word(w, 1'b0, 8'h00);
      w.kind = KIND_READ;
      w.addr = 8'd2;
      offer_word(w, 1'b0, 8'h00);
    end

    settle_outputs();
    repeat (8) @(posedge clk);
    leftover = read_bytes_due.size();
    $display("Sent %0d words: directed table, six random phases over schemes 0-3 and pulse",
             words_sent);
    $display("lengths 0..131071, coin queue fill/drain; %0d checked, %0d bad, %0d left over",
             words_checked, bad_words, leftover);
    if (bad_words == 0 && leftover == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aiopga_pkg.sv
sv/aiopga_tick.sv
sv/aiopga_regs.sv
sv/arcade_io_port_gate_array_top.sv
test/arcade_io_port_gate_array_top_tb.sv
